@@ rtl/xcfl_pkg.sv @@
`default_nettype none
package xcfl_pkg;
  localparam int PAYLOAD_BYTES = 128;
  localparam int PAW = $clog2(PAYLOAD_BYTES);
  localparam int CW = $clog2(PAYLOAD_BYTES + 5);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RECV    = 4'd1,
    PH_ER_WE   = 4'd2,
    PH_ER_CMD  = 4'd3,
    PH_ER_POLL = 4'd4,
    PH_PG_WE   = 4'd5,
    PH_PG_CMD  = 4'd6,
    PH_PG_POLL = 4'd7,
    PH_RD      = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    K_HOST  = 2'd0,
    K_TICK  = 2'd1,
    K_SLOT  = 2'd2,
    K_START = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_MASK  = 2'd1;
  localparam logic [1:0] CFG_RETRY = 2'd2;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_CTRLC = 8'h03;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NACK  = 8'h15;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] SPI_WREN = 8'h06;
  localparam logic [7:0] SPI_SE   = 8'hD8;
  localparam logic [7:0] SPI_RDSR = 8'h05;
  localparam logic [7:0] SPI_PP   = 8'h02;
  localparam logic [7:0] SPI_READ = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

@@ rtl/xcfl_if.sv @@
`default_nettype none
interface xcfl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface xcfl_out_if;
  logic       valid;
  logic       ready;
  logic       host_valid;
  logic [7:0] host_byte;
  logic       spi_valid;
  logic [7:0] spi_byte;
  logic       spi_last;
  logic       busy_res;
  logic       session_done;
  modport source (output valid, host_valid, host_byte, spi_valid, spi_byte, spi_last,
                  busy_res, session_done, input ready);
  modport sink (input valid, host_valid, host_byte, spi_valid, spi_byte, spi_last,
                busy_res, session_done, output ready);
endinterface

interface xcfl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/xmodem_crc_flash_loader.sv @@
`default_nettype none
// Each input beat yields one result beat. A new beat is not accepted while one
// is in flight, or while the output slot is full and not being taken. The frame
// store is read first (one synchronous port), then state and the output register are loaded.
// The output register frees as soon as its beat is taken.
// Reset (rst_n low, synchronous): idle, block 1, registers at defaults;
// frame store contents undefined until written.
module xmodem_crc_flash_loader (
  input wire logic clk,
  input wire logic rst_n,
  xcfl_in_if.sink   in_ch,
  xcfl_out_if.source out_ch,
  xcfl_cfg_if.sink  cfg_ch
);
  import xcfl_pkg::*;

  // configuration
  logic [23:0] start_addr_r, erase_mask_r;
  logic [15:0] retry_r;

  // state
  phase_t      phase_r, phase_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt, step_r, step_nxt;
  logic [7:0]  blk_r, blk_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [15:0] rcrc_r, rcrc_nxt, fcrc_r, fcrc_nxt, ticks_r, ticks_nxt;
  logic        seen_r, seen_nxt, hok_r, hok_nxt;

  // frame store
  logic [7:0] mem [PAYLOAD_BYTES];
  logic [7:0] rd_r;
  logic       we;
  logic [PAW-1:0] waddr;

  // stage: captured beat waiting for the memory read
  logic       s1_r;
  logic [1:0] k_r;
  logic [7:0] b_r;

  // output register
  logic       ov_r;
  logic       hv_r, sv_r, sl_r, busy_r, done_r;
  logic [7:0] hb_r, sb_r;
  logic       hv, sv, sl, done;
  logic [7:0] hb, sb;

  assign cfg_ch.ready = 1'b1;
  // accept only when no beat is in flight and the output slot will be free
  assign in_ch.ready = !s1_r && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= 24'd0;
      erase_mask_r <= 24'h07FFFF;
      retry_r <= 16'd100;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_START: start_addr_r <= cfg_ch.data;
        CFG_MASK:  erase_mask_r <= cfg_ch.data;
        CFG_RETRY: retry_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // read address: next program byte for the page program sequence
  logic [CW-1:0] rsel;
  logic [CW-1:0] rnext;
  always_comb begin
    rnext = (in_ch.kind == K_SLOT && phase_r == PH_PG_WE) ? CW'(0) : step_r + CW'(1);
    rsel = rnext - CW'(4);
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) rd_r <= mem[rsel[PAW-1:0]];
    if (we) mem[waddr] <= b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r <= 1'b0;
    else s1_r <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      k_r <= in_ch.kind;
      b_r <= in_ch.data_byte;
    end
  end

  function automatic logic [7:0] abyte(input logic [23:0] a, input logic [CW-1:0] i);
    if (i == CW'(1)) return a[23:16];
    if (i == CW'(2)) return a[15:8];
    return a[7:0];
  endfunction

  logic busy;
  logic emit;
  logic [CW-1:0] pidx;
  always_comb begin
    phase_nxt = phase_r; fcnt_nxt = fcnt_r; step_nxt = step_r; blk_nxt = blk_r;
    addr_nxt = addr_r; rcrc_nxt = rcrc_r; fcrc_nxt = fcrc_r; ticks_nxt = ticks_r;
    seen_nxt = seen_r; hok_nxt = hok_r;
    hv = 1'b0; hb = 8'h00; sv = 1'b0; sb = 8'h00; sl = 1'b0; done = 1'b0;
    emit = 1'b0; we = 1'b0;
    pidx = fcnt_r - CW'(3);
    waddr = pidx[PAW-1:0];
    busy = (phase_r >= PH_ER_WE);
    case (kind_t'(k_r))
      K_START: begin
        if (!busy) begin
          phase_nxt = PH_RECV; addr_nxt = start_addr_r; blk_nxt = 8'd1;
          fcnt_nxt = '0; rcrc_nxt = '0; fcrc_nxt = '0; step_nxt = '0;
          ticks_nxt = '0; seen_nxt = 1'b0; hok_nxt = 1'b0;
          hv = 1'b1; hb = CH_C;
        end
      end
      K_TICK: begin
        if (phase_r == PH_RECV && !seen_r) begin
          ticks_nxt = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
          if (ticks_nxt > retry_r) begin
            hv = 1'b1; hb = CH_C; ticks_nxt = '0;
          end
        end
      end
      K_HOST: begin
        if (phase_r == PH_RECV) begin
          seen_nxt = 1'b1;
          if (fcnt_r == CW'(0)) begin
            if (b_r == CH_CTRLC) begin
              phase_nxt = PH_IDLE; done = 1'b1;
            end else if (b_r == CH_EOT) begin
              phase_nxt = PH_IDLE; done = 1'b1; hv = 1'b1; hb = CH_ACK;
            end else if (b_r == CH_SOH) begin
              fcnt_nxt = CW'(1);
            end else begin
              hv = 1'b1; hb = CH_NACK;
            end
          end else if (fcnt_r == CW'(1)) begin
            fcrc_nxt = {8'h00, b_r}; fcnt_nxt = CW'(2);
          end else if (fcnt_r == CW'(2)) begin
            hok_nxt = (fcrc_r[7:0] == blk_r) && (fcrc_r[15:8] == 8'h00)
                      && (b_r == ~fcrc_r[7:0]);
            rcrc_nxt = '0; fcnt_nxt = CW'(3);
          end else if (fcnt_r < CW'(3 + PAYLOAD_BYTES)) begin
            we = 1'b1;
            rcrc_nxt = crc_add(rcrc_r, b_r);
            fcnt_nxt = fcnt_r + CW'(1);
          end else if (fcnt_r == CW'(3 + PAYLOAD_BYTES)) begin
            fcrc_nxt = {b_r, 8'h00}; fcnt_nxt = fcnt_r + CW'(1);
          end else begin
            fcrc_nxt = fcrc_r | {8'h00, b_r};
            fcnt_nxt = '0;
            if (hok_r && rcrc_r == fcrc_nxt) begin
              phase_nxt = ((addr_r & erase_mask_r) == 24'd0) ? PH_ER_WE : PH_PG_WE;
              step_nxt = '0; emit = 1'b1;
            end else begin
              hv = 1'b1; hb = CH_NACK;
            end
          end
        end
      end
      default: begin
        if (busy) begin
          emit = 1'b1;
          case (phase_r)
            PH_ER_WE: begin phase_nxt = PH_ER_CMD; step_nxt = '0; end
            PH_ER_CMD: begin
              if (step_r < CW'(3)) step_nxt = step_r + CW'(1);
              else begin phase_nxt = PH_ER_POLL; step_nxt = '0; end
            end
            PH_ER_POLL, PH_PG_POLL: begin
              if (step_r == CW'(0)) step_nxt = CW'(1);
              else if (b_r[0]) step_nxt = '0;
              else begin
                phase_nxt = (phase_r == PH_ER_POLL) ? PH_PG_WE : PH_RD;
                step_nxt = '0; rcrc_nxt = '0;
              end
            end
            PH_PG_WE: begin phase_nxt = PH_PG_CMD; step_nxt = '0; end
            PH_PG_CMD: begin
              if (step_r < CW'(3 + PAYLOAD_BYTES)) step_nxt = step_r + CW'(1);
              else begin phase_nxt = PH_PG_POLL; step_nxt = '0; end
            end
            default: begin
              if (step_r >= CW'(4)) rcrc_nxt = crc_add(rcrc_r, b_r);
              if (step_r < CW'(3 + PAYLOAD_BYTES)) step_nxt = step_r + CW'(1);
              else begin
                emit = 1'b0; hv = 1'b1;
                if (rcrc_nxt == fcrc_r) begin
                  hb = CH_ACK; blk_nxt = blk_r + 8'd1;
                  addr_nxt = addr_r + 24'(PAYLOAD_BYTES);
                end else hb = CH_NACK;
                phase_nxt = PH_RECV; step_nxt = '0; fcnt_nxt = '0;
              end
            end
          endcase
        end
      end
    endcase
    // SPI byte for the new phase and step
    if (emit) begin
      sv = 1'b1;
      case (phase_nxt)
        PH_ER_WE, PH_PG_WE: begin sb = SPI_WREN; sl = 1'b1; end
        PH_ER_CMD: begin
          sb = (step_nxt == CW'(0)) ? SPI_SE : abyte(addr_nxt, step_nxt);
          sl = (step_nxt >= CW'(3));
        end
        PH_ER_POLL, PH_PG_POLL: begin
          sb = (step_nxt == CW'(0)) ? SPI_RDSR : 8'h00;
          sl = (step_nxt != CW'(0));
        end
        PH_PG_CMD: begin
          if (step_nxt == CW'(0)) sb = SPI_PP;
          else if (step_nxt < CW'(4)) sb = abyte(addr_nxt, step_nxt);
          else begin
            sb = rd_r; sl = (step_nxt >= CW'(3 + PAYLOAD_BYTES));
          end
        end
        PH_RD: begin
          if (step_nxt == CW'(0)) sb = SPI_READ;
          else if (step_nxt < CW'(4)) sb = abyte(addr_nxt, step_nxt);
          else begin
            sb = 8'h00; sl = (step_nxt >= CW'(3 + PAYLOAD_BYTES));
          end
        end
        default: sb = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; fcnt_r <= '0; step_r <= '0; blk_r <= 8'd1;
      addr_r <= '0; rcrc_r <= '0; fcrc_r <= '0; ticks_r <= '0;
      seen_r <= 1'b0; hok_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (s1_r) begin
        phase_r <= phase_nxt; fcnt_r <= fcnt_nxt; step_r <= step_nxt; blk_r <= blk_nxt;
        addr_r <= addr_nxt; rcrc_r <= rcrc_nxt; fcrc_r <= fcrc_nxt; ticks_r <= ticks_nxt;
        seen_r <= seen_nxt; hok_r <= hok_nxt;
      end
      // advance the output slot: load a fresh beat, or drop a taken one
      if (s1_r) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    if (s1_r) begin
      hv_r <= hv; hb_r <= hb; sv_r <= sv; sb_r <= sb; sl_r <= sl;
      busy_r <= (phase_nxt >= PH_ER_WE); done_r <= done;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.host_valid = hv_r;
  assign out_ch.host_byte = hb_r;
  assign out_ch.spi_valid = sv_r;
  assign out_ch.spi_byte = sb_r;
  assign out_ch.spi_last = sl_r;
  assign out_ch.busy_res = busy_r;
  assign out_ch.session_done = done_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r |-> !in_ch.ready) else $error("second beat accepted during processing");
  a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r |=> out_ch.valid) else $error("result beat missing");
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.spi_last) |-> out_ch.spi_valid)
    else $error("spi_last without spi byte");
endmodule
`default_nettype wire

@@ dv/tb_xcfl_if.sv @@
`timescale 1ns / 1ps
// Testbench-side interfaces are the RTL ones; this file only keeps the
// interface slot of the build order and adds a beat record type.
package tb_xcfl_types;
  typedef struct packed {
    logic       host_valid;
    logic [7:0] host_byte;
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic       spi_last;
    logic       busy_res;
    logic       session_done;
  } loader_beat_t;
endpackage

@@ dv/tb_xmodem_crc_flash_loader.sv @@
`timescale 1ns / 1ps
module tb_xmodem_crc_flash_loader;
  import xcfl_pkg::*;
  import tb_xcfl_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  xcfl_in_if  in_ch ();
  xcfl_out_if out_ch ();
  xcfl_cfg_if cfg_ch ();

  xmodem_crc_flash_loader i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Shadow state of the loader.
  logic [23:0] sh_start, sh_mask, sh_addr;
  logic [15:0] sh_retry, sh_ticks, sh_rcrc, sh_fcrc;
  phase_t      sh_phase;
  int          sh_fcount, sh_step;
  logic [7:0]  sh_store [PAYLOAD_BYTES];
  logic [7:0]  sh_block;
  logic        sh_seen, sh_hdr_ok;

  loader_beat_t expected_beats[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0, recv_gap_pct = 0;
  int hold_off = 0;

  // Protocol model of the flash: status busy count; read data comes from the shadow store.
  int flash_busy_left;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic logic [7:0] addr_part(int idx);
    if (idx == 1) return sh_addr[23:16];
    if (idx == 2) return sh_addr[15:8];
    return sh_addr[7:0];
  endfunction

  // Next SPI byte for the current phase and step, with its chip-select end.
  function automatic logic [8:0] spi_next();
    int i;
    i = sh_step;
    case (sh_phase)
      PH_ER_WE, PH_PG_WE: return {1'b1, SPI_WREN};
      PH_ER_CMD: begin
        if (i == 0) return {1'b0, SPI_SE};
        return {i >= 3, addr_part(i)};
      end
      PH_ER_POLL, PH_PG_POLL: begin
        if (i == 0) return {1'b0, SPI_RDSR};
        return {1'b1, 8'h00};
      end
      PH_PG_CMD: begin
        if (i == 0) return {1'b0, SPI_PP};
        if (i < 4) return {1'b0, addr_part(i)};
        return {i >= 3 + PAYLOAD_BYTES, sh_store[i - 4]};
      end
      PH_RD: begin
        if (i == 0) return {1'b0, SPI_READ};
        if (i < 4) return {1'b0, addr_part(i)};
        return {i >= 3 + PAYLOAD_BYTES, 8'h00};
      end
      default: return 9'h0;
    endcase
  endfunction

  function automatic void open_session();
    sh_phase = PH_RECV; sh_addr = sh_start; sh_block = 8'd1; sh_fcount = 0;
    sh_rcrc = 0; sh_fcrc = 0; sh_step = 0; sh_ticks = 0; sh_seen = 0;
    sh_hdr_ok = 0;
  endfunction

  // Predict the beat caused by one accepted item and queue it.
  function automatic void predict_loader(kind_t kind, logic [7:0] b);
    loader_beat_t r;
    logic busy, emit;
    logic [8:0] s;
    int i;
    r = '0; emit = 0;
    busy = sh_phase >= PH_ER_WE;
    case (kind)
      K_START: if (!busy) begin
        open_session(); r.host_valid = 1; r.host_byte = CH_C;
      end
      K_TICK: if (sh_phase == PH_RECV && !sh_seen) begin
        if (sh_ticks != 16'hFFFF) sh_ticks++;
        if (sh_ticks > sh_retry) begin
          r.host_valid = 1; r.host_byte = CH_C; sh_ticks = 0;
        end
      end
      K_HOST: if (sh_phase == PH_RECV) begin
        sh_seen = 1;
        if (sh_fcount == 0) begin
          if (b == CH_CTRLC) begin
            sh_phase = PH_IDLE; r.session_done = 1;
          end else if (b == CH_EOT) begin
            sh_phase = PH_IDLE; r.session_done = 1; r.host_valid = 1; r.host_byte = CH_ACK;
          end else if (b == CH_SOH) begin
            sh_fcount = 1;
          end else begin
            r.host_valid = 1; r.host_byte = CH_NACK;
          end
        end else if (sh_fcount == 1) begin
          sh_fcrc = {8'h00, b}; sh_fcount = 2;
        end else if (sh_fcount == 2) begin
          sh_hdr_ok = (sh_fcrc == sh_block) && (b == 8'hFF - sh_fcrc[7:0]);
          sh_rcrc = 0; sh_fcount = 3;
        end else if (sh_fcount < 3 + PAYLOAD_BYTES) begin
          sh_store[sh_fcount - 3] = b; sh_rcrc = crc_step(sh_rcrc, b); sh_fcount++;
        end else if (sh_fcount == 3 + PAYLOAD_BYTES) begin
          sh_fcrc = {b, 8'h00}; sh_fcount++;
        end else begin
          sh_fcrc[7:0] = b; sh_fcount = 0;
          if (sh_hdr_ok && sh_rcrc == sh_fcrc) begin
            sh_phase = ((sh_addr & sh_mask) == 0) ? PH_ER_WE : PH_PG_WE;
            sh_step = 0; emit = 1;
          end else begin
            r.host_valid = 1; r.host_byte = CH_NACK;
          end
        end
      end
      default: if (busy) begin
        i = sh_step; emit = 1;
        case (sh_phase)
          PH_ER_WE: begin sh_phase = PH_ER_CMD; sh_step = 0; end
          PH_ER_CMD: if (i < 3) sh_step = i + 1;
                     else begin sh_phase = PH_ER_POLL; sh_step = 0; end
          PH_ER_POLL, PH_PG_POLL: begin
            if (i == 0) sh_step = 1;
            else if (b[0]) sh_step = 0;
            else begin
              sh_phase = (sh_phase == PH_ER_POLL) ? PH_PG_WE : PH_RD;
              sh_step = 0; sh_rcrc = 0;
            end
          end
          PH_PG_WE: begin sh_phase = PH_PG_CMD; sh_step = 0; end
          PH_PG_CMD: if (i < 3 + PAYLOAD_BYTES) sh_step = i + 1;
                     else begin sh_phase = PH_PG_POLL; sh_step = 0; end
          default: begin
            if (i >= 4) sh_rcrc = crc_step(sh_rcrc, b);
            if (i < 3 + PAYLOAD_BYTES) sh_step = i + 1;
            else begin
              emit = 0; r.host_valid = 1;
              if (sh_rcrc == sh_fcrc) begin
                r.host_byte = CH_ACK; sh_block++; sh_addr += 24'(PAYLOAD_BYTES);
              end else r.host_byte = CH_NACK;
              sh_phase = PH_RECV; sh_step = 0; sh_fcount = 0;
            end
          end
        endcase
      end
    endcase
    if (emit) begin
      s = spi_next();
      r.spi_valid = 1; r.spi_byte = s[7:0]; r.spi_last = s[8];
    end
    r.busy_res = sh_phase >= PH_ER_WE;
    expected_beats.push_back(r);
  endfunction

  // Drive one item and hold valid until the handshake. Valid stays up after
  // the beat so the next item can follow directly; drop it while idling.
  task automatic send_item(kind_t kind, logic [7:0] b);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_loader(kind, b);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_START: sh_start = val;
      CFG_MASK:  sh_mask = val;
      default:   sh_retry = val[15:0];
    endcase
  endtask

  // Drop valid, drain every expected beat, then let the pipe settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Answer every SPI byte with a slot beat; the flash reports busy for a few
  // polls and returns the programmed data, or a corrupted byte when asked.
  task automatic run_flash(bit corrupt);
    logic [7:0] rd;
    while (sh_phase >= PH_ER_WE) begin
      rd = 8'($urandom);
      if (sh_phase == PH_ER_POLL || sh_phase == PH_PG_POLL) begin
        if (sh_step == 1) begin
          rd[0] = flash_busy_left > 0;
          if (flash_busy_left > 0) flash_busy_left--;
        end
      end else if (sh_phase == PH_RD && sh_step >= 4) begin
        rd = sh_store[sh_step - 4];
        if (corrupt && sh_step == 40) rd = ~rd;
      end else if (sh_phase == PH_PG_CMD) flash_busy_left = $urandom_range(3);
      else if (sh_phase == PH_ER_CMD) flash_busy_left = $urandom_range(2);
      send_item(K_SLOT, rd);
    end
  endtask

  // One full frame: header, payload, CRC; good frames run the flash sequence.
  task automatic send_frame(logic [7:0] blk, bit bad_hdr, bit bad_crc, bit corrupt,
                            bit all_ff);
    logic [7:0] pl [PAYLOAD_BYTES];
    logic [15:0] c;
    c = 0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      pl[k] = all_ff ? 8'hFF : 8'($urandom);
      c = crc_step(c, pl[k]);
    end
    if (bad_crc) c ^= 16'h0001 << $urandom_range(15);
    send_item(K_HOST, CH_SOH);
    send_item(K_HOST, blk);
    send_item(K_HOST, bad_hdr ? blk : ~blk);
    for (int k = 0; k < PAYLOAD_BYTES; k++) send_item(K_HOST, pl[k]);
    send_item(K_HOST, c[15:8]);
    send_item(K_HOST, c[7:0]);
    run_flash(corrupt);
  endtask

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin
    loader_beat_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.host_valid, out_ch.host_byte, out_ch.spi_valid, out_ch.spi_byte,
              out_ch.spi_last, out_ch.busy_res, out_ch.session_done};
      if (expected_beats.size() == 0) report_mismatch("result beat with none expected");
      else begin
        want = expected_beats.pop_front();
        if (got.host_valid !== want.host_valid) report_mismatch("host_valid");
        if (got.host_byte !== want.host_byte) report_mismatch("host_byte");
        if (got.spi_valid !== want.spi_valid) report_mismatch("spi_valid");
        if (got.spi_byte !== want.spi_byte) report_mismatch("spi_byte");
        if (got.spi_last !== want.spi_last) report_mismatch("spi_last");
        if (got.busy_res !== want.busy_res) report_mismatch("busy_res");
        if (got.session_done !== want.session_done) report_mismatch("session_done");
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= $urandom_range(99) >= recv_gap_pct;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_off > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(K_HOST, CH_SOH);          // idle block ignores host bytes
    send_item(K_TICK, 8'h00);
    send_item(K_SLOT, 8'hFF);           // stray slot
    wait_drained();
    write_reg(CFG_RETRY, 24'd0);
    send_item(K_START, 8'h00);
    send_item(K_TICK, 8'h00);           // every tick resends
    send_item(K_TICK, 8'h00);
    send_item(K_HOST, 8'hFF);           // bad first byte
    send_item(K_HOST, 8'h00);
    send_item(K_HOST, CH_CTRLC);
    send_item(K_START, 8'h00);
    send_item(K_HOST, CH_EOT);
    send_item(K_START, 8'h00);
    send_item(K_HOST, CH_SOH);
    send_item(K_START, 8'h00);          // restart mid frame
    send_item(K_HOST, CH_EOT);
  endtask

  // Good frame on the last page before the address wraps, with erase, then
  // header errors and a restart.
  task automatic test_frames();
    send_item(K_START, 8'h00);
    send_frame(8'd1, 0, 0, 0, 1);
    send_frame(8'd2, 1, 0, 0, 0);       // bad complement
    send_frame(8'd7, 0, 0, 0, 0);       // wrong block
    send_item(K_START, 8'h00);
    send_item(K_HOST, CH_EOT);
  endtask

  task automatic test_tick_retry();
    wait_drained();
    write_reg(CFG_RETRY, 24'd3);
    send_item(K_START, 8'h00);
    repeat (9) send_item(K_TICK, 8'h00);
    wait_drained();
    write_reg(CFG_RETRY, 24'd65535);
    send_item(K_START, 8'h00);
    repeat (5) send_item(K_TICK, 8'h00);
    send_item(K_HOST, CH_CTRLC);
  endtask

  task automatic test_backpressure();
    send_item(K_START, 8'h00);
    hold_off <= 300;
    repeat (20) send_item(K_TICK, 8'h00);
    send_item(K_HOST, CH_CTRLC);
    wait_drained();                     // sender pauses until all beats returned
    send_item(K_START, 8'h00);
    send_item(K_HOST, CH_EOT);
  endtask

  task automatic test_bad_crc();
    send_item(K_START, 8'h00);
    send_frame(8'd1, 0, 1, 0, 0);
    send_item(K_HOST, CH_CTRLC);
  endtask

  task automatic test_readback_error();
    send_item(K_START, 8'h00);
    send_frame(8'd1, 0, 0, 1, 0);
    send_item(K_HOST, CH_EOT);
  endtask

  initial begin
    in_ch.valid = 0; in_ch.kind = K_HOST; in_ch.data_byte = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_START; cfg_ch.data = 0;
    sh_start = 0; sh_mask = 24'h07FFFF; sh_retry = 16'd100;
    sh_phase = PH_IDLE; sh_addr = 0; sh_block = 1; sh_fcount = 0; sh_step = 0;
    sh_rcrc = 0; sh_fcrc = 0; sh_ticks = 0; sh_seen = 0; sh_hdr_ok = 0;
    flash_busy_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 26; recv_gap_pct = 83;
    test_directed();
    wait_drained();
    write_reg(CFG_START, 24'hFFFFC0);   // address wrap after the first page
    write_reg(CFG_MASK, 24'h00003F);    // erase on that page
    test_frames();
    test_tick_retry();

    wait_drained();
    send_gap_pct = 83; recv_gap_pct = 26;
    write_reg(CFG_START, 24'h000000);
    write_reg(CFG_MASK, 24'hFFFFFF);    // erase only at address zero
    write_reg(CFG_RETRY, 24'd1);
    test_backpressure();
    test_bad_crc();

    wait_drained();
    send_gap_pct = 0; recv_gap_pct = 0;
    write_reg(CFG_START, 24'($urandom));
    write_reg(CFG_MASK, 24'h0000FF);
    write_reg(CFG_RETRY, 24'd100);
    test_readback_error();

    wait_drained();
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
